// ----- rtl/bsi_pkg.sv -----
// ----------------------------------------------------------------------------
// bsi_pkg
// Types, codes and constants of the boot script interpreter.
// ----------------------------------------------------------------------------
package bsi_pkg;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_STRICT_PEEK = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_PC    = 1'b1;

  localparam logic [31:0] START_PC_RESET = 32'hFF00_0080;

  // input item kinds
  localparam logic OP_EXEC      = 1'b0;
  localparam logic OP_READ_RESP = 1'b1;

  // instruction codes
  localparam logic [7:0] CODE_NOP1    = 8'h01;
  localparam logic [7:0] CODE_PEEK    = 8'h02;
  localparam logic [7:0] CODE_POKE    = 8'h03;
  localparam logic [7:0] CODE_POKEPCI = 8'h04;
  localparam logic [7:0] CODE_PEEKPCI = 8'h05;
  localparam logic [7:0] CODE_ANDOR   = 8'h06;
  localparam logic [7:0] CODE_PREFIX  = 8'h07;
  localparam logic [7:0] CODE_BNE     = 8'h08;
  localparam logic [7:0] CODE_BRA     = 8'h09;
  localparam logic [7:0] CODE_OUTB    = 8'h11;
  localparam logic [7:0] CODE_INB     = 8'h12;
  localparam logic [7:0] CODE_NOP2    = 8'h80;
  localparam logic [7:0] CODE_END     = 8'hEE;
  localparam logic [7:0] CODE_NOP3    = 8'hF5;

  // request kinds
  localparam logic [2:0] KIND_NONE      = 3'd0;
  localparam logic [2:0] KIND_MEM_RD    = 3'd1;
  localparam logic [2:0] KIND_MEM_WR    = 3'd2;
  localparam logic [2:0] KIND_PORT_WR32 = 3'd3;
  localparam logic [2:0] KIND_PORT_RD32 = 3'd4;
  localparam logic [2:0] KIND_PORT_WR8  = 3'd5;
  localparam logic [2:0] KIND_PORT_RD8  = 3'd6;

  // status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_UNKNOWN = 2'd1;
  localparam logic [1:0] ST_ENDED   = 2'd2;
  localparam logic [1:0] ST_STOPPED = 2'd3;

  // outstanding read codes
  localparam logic [1:0] PEND_NONE      = 2'd0;
  localparam logic [1:0] PEND_MEM32     = 2'd1;
  localparam logic [1:0] PEND_PORT32    = 2'd2;
  localparam logic [1:0] PEND_PORT8     = 2'd3;

  // fixed addresses and masks
  localparam logic [31:0] PCI_ADDR_PORT = 32'h0000_0CF8;
  localparam logic [31:0] PCI_DATA_PORT = 32'h0000_0CFC;
  localparam logic [31:0] PEEK_LIMIT    = 32'hFF00_0000;
  localparam logic [31:0] PEEK_MASK     = 32'h0FFF_FFFF;
  localparam logic [31:0] INSTR_BYTES   = 32'd9;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] address;
    logic [31:0] write_data;
    logic [31:0] next_pc;
    logic [31:0] accumulator;
    logic [1:0]  status;
    logic        finished;
    logic        last;
  } res_t;

  function automatic res_t mk_res(input logic [2:0] kind, input logic [31:0] addr,
                                  input logic [31:0] data, input logic [31:0] pc,
                                  input logic [31:0] acc, input logic [1:0] status,
                                  input logic fin, input logic last);
    res_t r;
    r.kind        = kind;
    r.address     = addr;
    r.write_data  = data;
    r.next_pc     = pc;
    r.accumulator = acc;
    r.status      = status;
    r.finished    = fin;
    r.last        = last;
    return r;
  endfunction

endpackage

// ----- rtl/boot_script_interpreter_core.sv -----
// ----------------------------------------------------------------------------
// boot_script_interpreter_core
// Executes a boot init script one instruction request at a time.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_*) carries either an instruction (code, A, B) or
//   the data answering an outstanding read. The output channel (out_*)
//   carries bus requests and status, one or two requests per instruction;
//   out_last marks the final one. Requests that cause nothing (halted, stray
//   read data, instruction while a read is outstanding) are simply consumed.
//   The cfg_* port writes the strict peek flag and the start address; a
//   start address write also reloads the program counter.
// Timing:
//   An accepted request is decoded in the same cycle and its results appear
//   on out_* in the next cycle. A two-entry result queue lets a new request
//   be taken each cycle as long as the receiver keeps up; a request is
//   taken only when the queue will be empty after the current pop, so a
//   two-request instruction holds off the next request until its second is popped.
// Reset:
//   rst_n low clears the queue, the accumulator and the halt flag, and sets
//   the program counter to 0xFF000080. When out_ready is low the head
//   request holds and in_ready falls until it drains.
module boot_script_interpreter_core (
  input  logic                               clk,
  input  logic                               rst_n,
  // configuration
  input  logic                               cfg_we,
  input  logic [bsi_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bsi_pkg::CFG_DATA_W-1:0]     cfg_data,
  // input channel
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_opcode,
  input  logic [7:0]                         in_instr_code,
  input  logic [31:0]                        in_operand_a,
  input  logic [31:0]                        in_operand_b,
  input  logic [31:0]                        in_read_data,
  input  logic                               in_rom_enabled,
  // result channel
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [2:0]                         out_request_kind,
  output logic [31:0]                        out_address,
  output logic [31:0]                        out_write_data,
  output logic [31:0]                        out_next_pc,
  output logic [31:0]                        out_accumulator,
  output logic [1:0]                         out_status,
  output logic                               out_finished,
  output logic                               out_last
);
  import bsi_pkg::*;

  logic        strict_r;
  logic [31:0] pc_r, pc_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [1:0]  pend_r, pend_nxt;
  logic        halted_r, halted_nxt;

  res_t        q_r [2];
  logic [1:0]  cnt_r;

  res_t        res0, res1;
  logic [1:0]  n_res;
  logic [7:0]  code_e;
  logic [31:0] a_e, b_e, pc_inc;
  logic        in_fire, pop;

  // handshake
  assign out_valid = (cnt_r != 2'd0);
  assign pop       = out_valid && out_ready;
  assign in_ready  = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_ready);
  assign in_fire   = in_valid && in_ready;

  // prefix code takes the code from operand A; A gets B, B gets the accumulator
  always_comb begin
    if (in_instr_code == CODE_PREFIX) begin
      code_e = in_operand_a[7:0];
      a_e    = in_operand_b;
      b_e    = acc_r;
    end else begin
      code_e = in_instr_code;
      a_e    = in_operand_a;
      b_e    = in_operand_b;
    end
  end

  assign pc_inc = pc_r + INSTR_BYTES;

  // decode and execute
  always_comb begin
    n_res      = 2'd0;
    res0       = '0;
    res1       = '0;
    pc_nxt     = pc_r;
    acc_nxt    = acc_r;
    pend_nxt   = pend_r;
    halted_nxt = halted_r;
    if (!halted_r) begin
      if (in_opcode == OP_READ_RESP) begin
        if (pend_r != PEND_NONE) begin
          acc_nxt  = (pend_r == PEND_PORT8) ? {24'd0, in_read_data[7:0]} : in_read_data;
          pend_nxt = PEND_NONE;
          res0     = mk_res(KIND_NONE, '0, '0, pc_r, acc_nxt, ST_OK, 1'b0, 1'b1);
          n_res    = 2'd1;
        end
      end else if (pend_r == PEND_NONE) begin
        if (!in_rom_enabled) begin
          halted_nxt = 1'b1;
          res0       = mk_res(KIND_NONE, '0, '0, pc_r, acc_r, ST_STOPPED, 1'b1, 1'b1);
          n_res      = 2'd1;
        end else begin
          pc_nxt = pc_inc;
          n_res  = 2'd1;
          res0   = mk_res(KIND_NONE, '0, '0, pc_inc, acc_r, ST_OK, 1'b0, 1'b1);
          unique case (code_e)
            CODE_PEEK: begin
              if (strict_r) begin
                if (a_e <= PEEK_LIMIT) begin
                  pend_nxt = PEND_MEM32;
                  res0 = mk_res(KIND_MEM_RD, a_e, '0, pc_inc, acc_r, ST_OK, 1'b0, 1'b1);
                end
              end else begin
                pend_nxt = PEND_MEM32;
                res0 = mk_res(KIND_MEM_RD, a_e & PEEK_MASK, '0, pc_inc, acc_r, ST_OK,
                              1'b0, 1'b1);
              end
            end
            CODE_POKE: begin
              res0 = mk_res(KIND_MEM_WR, a_e, b_e, pc_inc, acc_r, ST_OK, 1'b0, 1'b1);
            end
            CODE_POKEPCI: begin
              n_res = 2'd2;
              res0 = mk_res(KIND_PORT_WR32, PCI_ADDR_PORT, a_e, pc_inc, acc_r, ST_OK,
                            1'b0, 1'b0);
              res1 = mk_res(KIND_PORT_WR32, PCI_DATA_PORT, b_e, pc_inc, acc_r, ST_OK,
                            1'b0, 1'b1);
            end
            CODE_PEEKPCI: begin
              n_res    = 2'd2;
              pend_nxt = PEND_PORT32;
              res0 = mk_res(KIND_PORT_WR32, PCI_ADDR_PORT, a_e, pc_inc, acc_r, ST_OK,
                            1'b0, 1'b0);
              res1 = mk_res(KIND_PORT_RD32, PCI_DATA_PORT, '0, pc_inc, acc_r, ST_OK,
                            1'b0, 1'b1);
            end
            CODE_ANDOR: begin
              acc_nxt = (acc_r & a_e) | b_e;
              res0 = mk_res(KIND_NONE, '0, '0, pc_inc, acc_nxt, ST_OK, 1'b0, 1'b1);
            end
            CODE_BNE: begin
              if (acc_r != a_e) begin
                pc_nxt = pc_inc + b_e;
              end
              res0 = mk_res(KIND_NONE, '0, '0, pc_nxt, acc_r, ST_OK, 1'b0, 1'b1);
            end
            CODE_BRA: begin
              pc_nxt = pc_inc + b_e;
              res0 = mk_res(KIND_NONE, '0, '0, pc_nxt, acc_r, ST_OK, 1'b0, 1'b1);
            end
            CODE_OUTB: begin
              res0 = mk_res(KIND_PORT_WR8, {16'd0, a_e[15:0]}, {24'd0, b_e[7:0]}, pc_inc,
                            acc_r, ST_OK, 1'b0, 1'b1);
            end
            CODE_INB: begin
              pend_nxt = PEND_PORT8;
              res0 = mk_res(KIND_PORT_RD8, {16'd0, a_e[15:0]}, '0, pc_inc, acc_r, ST_OK,
                            1'b0, 1'b1);
            end
            CODE_END: begin
              halted_nxt = 1'b1;
              res0 = mk_res(KIND_NONE, a_e, b_e, pc_inc, acc_r, ST_ENDED, 1'b1, 1'b1);
            end
            CODE_NOP1, CODE_NOP2, CODE_NOP3: begin
              res0 = mk_res(KIND_NONE, '0, '0, pc_inc, acc_r, ST_OK, 1'b0, 1'b1);
            end
            default: begin
              res0 = mk_res(KIND_NONE, '0, '0, pc_inc, acc_r, ST_UNKNOWN, 1'b0, 1'b1);
            end
          endcase
        end
      end
    end
  end

  // configuration registers and interpreter state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strict_r   <= 1'b0;
      pc_r       <= START_PC_RESET;
      acc_r      <= '0;
      pend_r     <= PEND_NONE;
      halted_r   <= 1'b0;
    end else begin
      if (cfg_we && (cfg_index == CFG_STRICT_PEEK)) begin
        strict_r <= cfg_data[0];
      end
      // a start address write reloads the program counter
      if (cfg_we && (cfg_index == CFG_START_PC)) begin
        pc_r <= cfg_data;
      end else if (in_fire) begin
        pc_r <= pc_nxt;
      end
      if (in_fire) begin
        acc_r    <= acc_nxt;
        pend_r   <= pend_nxt;
        halted_r <= halted_nxt;
      end
    end
  end

  // result queue count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else if (in_fire) begin
      cnt_r <= n_res;
    end else if (pop) begin
      cnt_r <= cnt_r - 2'd1;
    end
  end

  // result queue payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      q_r[0] <= res0;
      q_r[1] <= res1;
    end else if (pop) begin
      q_r[0] <= q_r[1];
    end
  end

  assign out_request_kind = q_r[0].kind;
  assign out_address      = q_r[0].address;
  assign out_write_data   = q_r[0].write_data;
  assign out_next_pc      = q_r[0].next_pc;
  assign out_accumulator  = q_r[0].accumulator;
  assign out_status       = q_r[0].status;
  assign out_finished     = q_r[0].finished;
  assign out_last         = q_r[0].last;

`ifndef SYNTHESIS
  // queue never holds more than two results
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3) else $error("result queue overflow");

  // a new request only lands in a queue that is empty or drains this cycle
  a_fire_empty: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> ((cnt_r == 2'd0) || pop)) else $error("request accepted over pending results");

  // halt is sticky until reset
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r |=> halted_r) else $error("halt flag cleared");

  // the block never halts with a read outstanding
  a_halt_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    !(halted_r && (pend_r != PEND_NONE))) else $error("halted with read outstanding");
`endif

endmodule

// ----- dv/tb_boot_script_interpreter_core.sv -----
// ----------------------------------------------------------------------------
// tb_boot_script_interpreter_core
// Self-checking bench: drives script instructions and read data through the
// valid/ready input channel, predicts every bus request and status result
// from a local copy of the interpreter state and compares each result field
// by field. Directed cases come first, then random scripts over several
// register settings, and the run ends with a halt and ignored traffic.
// ----------------------------------------------------------------------------
module tb_boot_script_interpreter_core;
  timeunit 1ns;
  timeprecision 1ps;

  import bsi_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;

  // one input request as the bench sees it
  typedef struct packed {
    logic        op;
    logic [7:0]  code;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] rd;
    logic        en;
  } script_req_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic        in_opcode;
  logic [7:0]  in_instr_code;
  logic [31:0] in_operand_a;
  logic [31:0] in_operand_b;
  logic [31:0] in_read_data;
  logic        in_rom_enabled;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_request_kind;
  logic [31:0] out_address;
  logic [31:0] out_write_data;
  logic [31:0] out_next_pc;
  logic [31:0] out_accumulator;
  logic [1:0]  out_status;
  logic        out_finished;
  logic        out_last;

  boot_script_interpreter_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_opcode        (in_opcode),
    .in_instr_code    (in_instr_code),
    .in_operand_a     (in_operand_a),
    .in_operand_b     (in_operand_b),
    .in_read_data     (in_read_data),
    .in_rom_enabled   (in_rom_enabled),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_request_kind (out_request_kind),
    .out_address      (out_address),
    .out_write_data   (out_write_data),
    .out_next_pc      (out_next_pc),
    .out_accumulator  (out_accumulator),
    .out_status       (out_status),
    .out_finished     (out_finished),
    .out_last         (out_last)
  );

  // interpreter state as predicted by the bench
  logic [31:0] pred_pc;
  logic [31:0] pred_acc;
  logic [1:0]  pred_pend;
  logic        pred_halted;
  logic        pred_strict;

  res_t        bus_ops_due[$];
  logic [255:0] codes_run;
  int unsigned cycle_count = 0;
  int unsigned n_sent;
  int unsigned n_effective;
  int unsigned n_checked;
  int unsigned n_reg_writes;
  int unsigned errors;

  // clock
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // cycle count and run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: run limit reached with %0d results still due", $time,
               bus_ops_due.size());
      $display("[boot_script_interpreter_core] ERROR");
      $finish;
    end
  end

  // a long window without any idling now and then
  function automatic bit calm_window();
    return (cycle_count % 3000) >= 2400;
  endfunction

  // receiver stalls
  always @(negedge clk) begin
    out_ready <= calm_window() || ($urandom_range(0, 99) >= 17);
  end

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  function automatic void due(input logic [2:0] kind, input logic [31:0] addr,
                              input logic [31:0] data, input logic [1:0] st,
                              input logic fin, input logic lst);
    res_t e;
    e = {kind, addr, data, pred_pc, pred_acc, st, fin, lst};
    bus_ops_due.push_back(e);
    if (lst) n_effective++;
  endfunction

  function automatic void interpret_step(input script_req_t r);
    logic [7:0]  code;
    logic [31:0] a;
    logic [31:0] b;
    if (pred_halted) return;
    // read data completes the outstanding read, stray data is dropped
    if (r.op == OP_READ_RESP) begin
      if (pred_pend == PEND_NONE) return;
      pred_acc = (pred_pend == PEND_PORT8) ? {24'd0, r.rd[7:0]} : r.rd;
      pred_pend = PEND_NONE;
      due(KIND_NONE, '0, '0, ST_OK, 1'b0, 1'b1);
      return;
    end
    if (pred_pend != PEND_NONE) return;
    if (!r.en) begin
      pred_halted = 1'b1;
      due(KIND_NONE, '0, '0, ST_STOPPED, 1'b1, 1'b1);
      return;
    end
    code = r.code;
    a = r.a;
    b = r.b;
    // prefix: code from low byte of a, operands shift
    if (code == CODE_PREFIX) begin
      code = a[7:0];
      a = b;
      b = pred_acc;
    end
    codes_run[code] = 1'b1;
    pred_pc = pred_pc + INSTR_BYTES;
    case (code)
      CODE_PEEK: begin
        if (pred_strict) begin
          if (a <= PEEK_LIMIT) begin
            pred_pend = PEND_MEM32;
            due(KIND_MEM_RD, a, '0, ST_OK, 1'b0, 1'b1);
          end else begin
            due(KIND_NONE, '0, '0, ST_OK, 1'b0, 1'b1);
          end
        end else begin
          pred_pend = PEND_MEM32;
          due(KIND_MEM_RD, a & PEEK_MASK, '0, ST_OK, 1'b0, 1'b1);
        end
      end
      CODE_POKE: due(KIND_MEM_WR, a, b, ST_OK, 1'b0, 1'b1);
      CODE_POKEPCI: begin
        due(KIND_PORT_WR32, PCI_ADDR_PORT, a, ST_OK, 1'b0, 1'b0);
        due(KIND_PORT_WR32, PCI_DATA_PORT, b, ST_OK, 1'b0, 1'b1);
      end
      CODE_PEEKPCI: begin
        pred_pend = PEND_PORT32;
        due(KIND_PORT_WR32, PCI_ADDR_PORT, a, ST_OK, 1'b0, 1'b0);
        due(KIND_PORT_RD32, PCI_DATA_PORT, '0, ST_OK, 1'b0, 1'b1);
      end
      CODE_ANDOR: begin
        pred_acc = (pred_acc & a) | b;
        due(KIND_NONE, '0, '0, ST_OK, 1'b0, 1'b1);
      end
      CODE_BNE: begin
        if (pred_acc != a) pred_pc = pred_pc + b;
        due(KIND_NONE, '0, '0, ST_OK, 1'b0, 1'b1);
      end
      CODE_BRA: begin
        pred_pc = pred_pc + b;
        due(KIND_NONE, '0, '0, ST_OK, 1'b0, 1'b1);
      end
      CODE_OUTB: due(KIND_PORT_WR8, {16'd0, a[15:0]}, {24'd0, b[7:0]}, ST_OK, 1'b0, 1'b1);
      CODE_INB: begin
        pred_pend = PEND_PORT8;
        due(KIND_PORT_RD8, {16'd0, a[15:0]}, '0, ST_OK, 1'b0, 1'b1);
      end
      CODE_END: begin
        pred_halted = 1'b1;
        due(KIND_NONE, a, b, ST_ENDED, 1'b1, 1'b1);
      end
      CODE_NOP1, CODE_NOP2, CODE_NOP3: due(KIND_NONE, '0, '0, ST_OK, 1'b0, 1'b1);
      default: due(KIND_NONE, '0, '0, ST_UNKNOWN, 1'b0, 1'b1);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------------

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin : result_monitor
    res_t want;
    res_t got;
    if (rst_n && out_valid && out_ready) begin
      got = {out_request_kind, out_address, out_write_data, out_next_pc,
             out_accumulator, out_status, out_finished, out_last};
      if (bus_ops_due.size() == 0) begin
        $display("%0t: unexpected result: expected none, got kind %0d addr %h status %0d",
                 $time, got.kind, got.address, got.status);
        errors++;
      end else begin
        want = bus_ops_due.pop_front();
        n_checked++;
        check_field("request_kind", 32'(want.kind), 32'(got.kind));
        check_field("address", want.address, got.address);
        check_field("write_data", want.write_data, got.write_data);
        check_field("next_pc", want.next_pc, got.next_pc);
        check_field("accumulator", want.accumulator, got.accumulator);
        check_field("status", 32'(want.status), 32'(got.status));
        check_field("finished", 32'(want.finished), 32'(got.finished));
        check_field("last", 32'(want.last), 32'(got.last));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // send one request, with an occasional gap before it
  task automatic push_request(input script_req_t r);
    int unsigned gap;
    gap = (!calm_window() && $urandom_range(0, 99) < 17) ? $urandom_range(1, 4) : 0;
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_opcode      <= r.op;
    in_instr_code  <= r.code;
    in_operand_a   <= r.a;
    in_operand_b   <= r.b;
    in_read_data   <= r.rd;
    in_rom_enabled <= r.en;
    in_valid       <= 1'b1;
    do @(posedge clk); while (!in_ready);
    n_sent++;
    interpret_step(r);
  endtask

  // drop valid and let every due result drain
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (bus_ops_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    drain();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
    n_reg_writes++;
    if (idx == CFG_STRICT_PEEK) pred_strict = data[0];
    else pred_pc = data;
  endtask

  function automatic logic [31:0] pick_word();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 8) return 32'h0;
    if (roll < 16) return 32'hFFFF_FFFF;
    if (roll < 26) return PEEK_LIMIT + $urandom_range(0, 2) - 1;
    return $urandom;
  endfunction

  function automatic logic [7:0] pick_known_code();
    case ($urandom_range(0, 11))
      0:  return CODE_NOP1;
      1:  return CODE_PEEK;
      2:  return CODE_POKE;
      3:  return CODE_POKEPCI;
      4:  return CODE_PEEKPCI;
      5:  return CODE_ANDOR;
      6:  return CODE_BNE;
      7:  return CODE_BRA;
      8:  return CODE_OUTB;
      9:  return CODE_INB;
      10: return CODE_NOP2;
      default: return CODE_NOP3;
    endcase
  endfunction

  function automatic script_req_t mk_exec(input logic [7:0] code, input logic [31:0] a,
                                          input logic [31:0] b);
    script_req_t r;
    r = {OP_EXEC, code, a, b, 32'($urandom), 1'b1};
    return r;
  endfunction

  function automatic script_req_t mk_read_data(input logic [31:0] rd);
    script_req_t r;
    r = {OP_READ_RESP, 8'($urandom), 32'($urandom), 32'($urandom), rd, 1'($urandom)};
    return r;
  endfunction

  // next random request, shaped by the predicted state
  function automatic script_req_t random_request();
    script_req_t r;
    int unsigned roll;
    r = {OP_EXEC, 8'($urandom), pick_word(), pick_word(), pick_word(), 1'b1};
    if (pred_pend != PEND_NONE) begin
      // mostly the read data, sometimes an instruction that gets dropped
      if ($urandom_range(0, 99) < 85) r.op = OP_READ_RESP;
      r.en = 1'($urandom);
      return r;
    end
    roll = $urandom_range(0, 99);
    if (roll < 5) begin
      r.op = OP_READ_RESP;
      r.en = 1'($urandom);
      return r;
    end
    if (roll < 70) begin
      r.code = pick_known_code();
    end else if (roll < 82) begin
      r.code = CODE_PREFIX;
      r.a[7:0] = ($urandom_range(0, 3) == 0) ? 8'($urandom) : pick_known_code();
      if (r.a[7:0] == CODE_END) r.a[7:0] = CODE_PREFIX;
      if (r.a[7:0] == CODE_BNE && $urandom_range(0, 1) == 1) r.b = pred_acc;
    end
    // the script must not end before the final phase
    if (r.code == CODE_END) r.code = CODE_NOP1;
    if (r.code == CODE_PREFIX && r.a[7:0] == CODE_END) r.a[7:0] = CODE_PREFIX;
    if (r.code == CODE_BNE && $urandom_range(0, 1) == 1) r.a = pred_acc;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  task automatic test_directed_ops();
    push_request(mk_exec(CODE_ANDOR, 32'h0, 32'hFFFF_FFFF));
    push_request(mk_exec(CODE_PEEK, 32'hFFFF_FFFF, 32'h0));
    push_request(mk_read_data(32'h1234_5678));
    // stray read data
    push_request(mk_read_data(32'hDEAD_BEEF));
    push_request(mk_exec(CODE_POKE, 32'hFFFF_FFFF, 32'h0));
    push_request(mk_exec(CODE_POKEPCI, 32'h8000_0000, 32'hFFFF_FFFF));
    push_request(mk_exec(CODE_PEEKPCI, 32'h8000_0004, 32'h0));
    // instruction while the read is outstanding, also with rom disabled
    push_request({OP_EXEC, CODE_POKE, 32'h1, 32'h2, 32'h0, 1'b0});
    push_request(mk_read_data(32'hFFFF_FFFF));
    push_request(mk_exec(CODE_OUTB, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    push_request(mk_exec(CODE_INB, 32'h0001_2380, 32'h0));
    push_request(mk_read_data(32'hFFFF_FFAB));
    // branch not taken, then taken backwards by one instruction
    push_request(mk_exec(CODE_BNE, 32'h0000_00AB, 32'h100));
    push_request(mk_exec(CODE_BNE, 32'h0, 32'hFFFF_FFF7));
    push_request(mk_exec(CODE_BRA, 32'h0, 32'h10));
    push_request(mk_exec(CODE_NOP1, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    push_request(mk_exec(CODE_NOP2, 32'h0, 32'h0));
    push_request(mk_exec(CODE_NOP3, 32'h0, 32'h0));
    push_request(mk_exec(8'hFF, 32'h0, 32'h0));
    // prefix forms, including a prefix selecting the prefix
    push_request(mk_exec(CODE_PREFIX, {24'h0, CODE_ANDOR}, 32'h0000_00F0));
    push_request(mk_exec(CODE_PREFIX, {24'hFFFFFF, CODE_PREFIX}, 32'h5));
  endtask

  task automatic test_strict_peek();
    write_reg(CFG_STRICT_PEEK, 32'h1);
    push_request(mk_exec(CODE_PEEK, PEEK_LIMIT, 32'h0));
    push_request(mk_read_data(32'h0BAD_F00D));
    push_request(mk_exec(CODE_PEEK, PEEK_LIMIT + 1, 32'h0));
  endtask

  task automatic test_random_phases();
    logic [31:0] settings_pc [5];
    logic        settings_strict [5];
    int unsigned mark;
    settings_pc[0] = 32'h0;          settings_strict[0] = 1'b0;
    settings_pc[1] = 32'hFFFF_FFFF;  settings_strict[1] = 1'b1;
    settings_pc[2] = START_PC_RESET; settings_strict[2] = 1'b0;
    settings_pc[3] = $urandom;       settings_strict[3] = 1'b1;
    settings_pc[4] = $urandom;       settings_strict[4] = 1'($urandom);
    for (int p = 0; p < 5; p++) begin
      write_reg(CFG_STRICT_PEEK, {31'd0, settings_strict[p]});
      write_reg(CFG_START_PC, settings_pc[p]);
      mark = n_effective;
      while (n_effective - mark < 340) push_request(random_request());
    end
  endtask

  task automatic test_halt_and_ignore();
    int unsigned mode;
    if (pred_pend != PEND_NONE) push_request(mk_read_data($urandom));
    mode = $urandom_range(0, 2);
    case (mode)
      0: push_request({OP_EXEC, 8'($urandom), 32'($urandom), 32'($urandom),
                       32'($urandom), 1'b0});
      1: push_request(mk_exec(CODE_END, $urandom, $urandom));
      default: push_request(mk_exec(CODE_PREFIX, {24'($urandom), CODE_END}, $urandom));
    endcase
    // everything after the halt is consumed silently
    repeat (10) begin
      push_request({1'($urandom), 8'($urandom), 32'($urandom), 32'($urandom),
                    32'($urandom), 1'($urandom)});
    end
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    in_valid       = 1'b0;
    in_opcode      = OP_EXEC;
    in_instr_code  = '0;
    in_operand_a   = '0;
    in_operand_b   = '0;
    in_read_data   = '0;
    in_rom_enabled = 1'b1;
    n_sent         = 0;
    n_effective    = 0;
    n_checked      = 0;
    n_reg_writes   = 0;
    errors         = 0;
    codes_run      = '0;
    pred_pc        = START_PC_RESET;
    pred_acc       = '0;
    pred_pend      = PEND_NONE;
    pred_halted    = 1'b0;
    pred_strict    = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_ops();
    test_strict_peek();
    test_random_phases();
    test_halt_and_ignore();

    drain();
    repeat (8) @(posedge clk);
    $display("run: %0d requests sent, %0d with results, %0d results checked",
             n_sent, n_effective, n_checked);
    $display("run: %0d distinct codes executed, %0d register writes, %0d mismatches",
             $countones(codes_run), n_reg_writes, errors);
    if (errors == 0 && bus_ops_due.size() == 0) begin
      $display("[boot_script_interpreter_core] OK");
    end else begin
      $display("[boot_script_interpreter_core] ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/bsi_pkg.sv
rtl/boot_script_interpreter_core.sv
dv/tb_boot_script_interpreter_core.sv
